// ===== src/aes_pkg.sv =====
`timescale 1ns / 1ps

package aes_pkg;

   localparam int ROUND_COUNT    = 14;
   localparam int SCHEDULE_WORDS = 60;
   localparam int KEY_REGS       = 4;
   localparam int RK_ADDR_W      = 4;

   // reduction polynomial and first round constant
   localparam logic [7:0] GF_POLY  = 8'h1b;
   localparam logic [7:0] RCON_INIT = 8'h01;

   // mix column coefficients, first row
   localparam logic [7:0] MIX_FWD [4] = '{8'h02, 8'h03, 8'h01, 8'h01};
   localparam logic [7:0] MIX_INV [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};

   localparam logic [7:0] FWD_TAB [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
   };

   localparam logic [7:0] INV_TAB [256] = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
   };

   // commands from the controller to the datapath
   typedef struct packed {
      logic                 key_load;   // load expansion window from key registers
      logic                 exp_step;   // write one round key, advance window
      logic [RK_ADDR_W-1:0] exp_idx;    // round key being written
      logic                 blk_load;   // capture input word
      logic                 rd_from_req; // take direction from the input port
      logic [RK_ADDR_W-1:0] rd_round;   // round whose key is fetched next
      logic                 init;       // initial key addition
      logic                 round_en;   // one cipher round
      logic                 last_round; // final round, no column mix
      logic                 out_load;   // move result to output register
   } cmd_type;

   function automatic logic [7:0] xtime(input logic [7:0] v);
      xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   // multiply by a coefficient of at most four bits
   function automatic logic [7:0] gf_mul(input logic [7:0] v, input logic [7:0] k);
      logic [7:0] acc;
      logic [7:0] p;
      acc = 8'h00;
      p   = v;
      for (int i = 0; i < 4; i++) begin
         if (k[i]) acc = acc ^ p;
         p = xtime(p);
      end
      gf_mul = acc;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {FWD_TAB[w[31:24]], FWD_TAB[w[23:16]], FWD_TAB[w[15:8]], FWD_TAB[w[7:0]]};
   endfunction

endpackage

// ===== src/aes256_ecb_block_cipher.sv =====
`timescale 1ns / 1ps

// AES-256 ECB cipher, one 128-bit block per input word.
// req channel: tdata carries the block (upper half in the low 64 bits, byte 0
// at bits 63:56), tuser selects encrypt (0) or decrypt (1), tlast is a
// final-block mark that comes back on rsp_tlast.
// rsp channel: tdata carries the result block packed the same way.
// csr port: csr_wen writes 64-bit key register csr_index (0 holds key bytes
// 0..7, byte 0 on top). Each write restarts key expansion: a load state, then
// an expansion state that writes the 15 round keys of 128 bits one by one,
// req_tready low meanwhile. Reset clears the key to zero and runs the same
// expansion. Sequence: the first key fetch overlaps the edge that accepts a
// word; then come the initial key addition, 14 rounds and the output load,
// after which rsp_tvalid rises. The round unit is shared by all rounds,
// so one block is in flight at a time; a new word is taken once it is done.
// A result waits in the output register while rsp_tready is low; the next word
// is accepted meanwhile, and its result holds in the core until that register
// frees up.
module aes256_ecb_block_cipher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // block_upper, block_lower
   input  logic         req_tuser,  // func
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // result_upper, result_lower
   output logic         rsp_tlast,
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   aes_pkg::cmd_type cmd;

   // sequencer
   aes_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // key schedule and round unit
   aes_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd)
   );

endmodule

// ===== src/aes_ctrl.sv =====
`timescale 1ns / 1ps

module aes_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output aes_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_KLOAD, S_KEXP, S_IDLE, S_INIT, S_ROUND, S_DONE
   } state_type;

   localparam logic [aes_pkg::RK_ADDR_W-1:0] LAST_RK = aes_pkg::RK_ADDR_W'(aes_pkg::ROUND_COUNT);

   state_type                     state_ff;
   logic [aes_pkg::RK_ADDR_W-1:0] cnt_ff;
   logic                          rsp_valid_ff;
   logic                          out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd             = '0;
      cmd.key_load    = (state_ff == S_KLOAD);
      cmd.exp_step    = (state_ff == S_KEXP);
      cmd.exp_idx     = cnt_ff;
      cmd.blk_load    = (state_ff == S_IDLE) && req_tvalid;
      cmd.rd_from_req = (state_ff == S_IDLE);
      cmd.init        = (state_ff == S_INIT);
      cmd.round_en    = (state_ff == S_ROUND);
      cmd.last_round  = (cnt_ff == LAST_RK);
      cmd.out_load    = (state_ff == S_DONE) && out_free;
      unique case (state_ff)
         S_IDLE:  cmd.rd_round = '0;
         S_INIT:  cmd.rd_round = aes_pkg::RK_ADDR_W'(1);
         S_ROUND: cmd.rd_round = cnt_ff + aes_pkg::RK_ADDR_W'(1);
         default: cmd.rd_round = '0;
      endcase
   end

   // sequencer and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_KLOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_wen) begin
            state_ff <= S_KLOAD;
         end else begin
            unique case (state_ff)
               S_KLOAD: begin
                  cnt_ff   <= '0;
                  state_ff <= S_KEXP;
               end
               S_KEXP: begin
                  cnt_ff <= cnt_ff + aes_pkg::RK_ADDR_W'(1);
                  if (cnt_ff == LAST_RK) state_ff <= S_IDLE;
               end
               S_IDLE: begin
                  if (req_tvalid) state_ff <= S_INIT;
               end
               S_INIT: begin
                  cnt_ff   <= aes_pkg::RK_ADDR_W'(1);
                  state_ff <= S_ROUND;
               end
               S_ROUND: begin
                  cnt_ff <= cnt_ff + aes_pkg::RK_ADDR_W'(1);
                  if (cnt_ff == LAST_RK) state_ff <= S_DONE;
               end
               S_DONE: begin
                  if (out_free) state_ff <= S_IDLE;
               end
               default: state_ff <= S_KLOAD;
            endcase
         end
      end
   end

endmodule

// ===== src/aes_datapath.sv =====
`timescale 1ns / 1ps

module aes_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   input  logic [127:0]     req_tdata,
   input  logic             req_tlast,
   input  logic             req_tuser,
   output logic [127:0]     rsp_tdata,
   output logic             rsp_tlast,
   input  aes_pkg::cmd_type cmd
);

   localparam int RK_DEPTH = aes_pkg::ROUND_COUNT + 1;

   logic [63:0]  key_ff [aes_pkg::KEY_REGS];
   logic [255:0] win_ff;
   logic [7:0]   rc_ff;
   logic [127:0] rk_mem [RK_DEPTH];
   logic [127:0] rk_q_ff;
   logic [127:0] st_ff;
   logic         dec_ff;
   logic         fin_ff;
   logic [127:0] out_ff;
   logic         out_fin_ff;

   logic [255:0] win_in;
   logic [31:0]  t_word;
   logic [31:0]  n0, n1, n2, n3;
   logic         rd_dec;
   logic [aes_pkg::RK_ADDR_W-1:0] rd_addr;
   logic [127:0] blk_be;
   logic [127:0] st_in;
   logic [7:0]   sb [16];
   logic [7:0]   mx [16];
   logic [7:0]   kb [16];
   logic [7:0]   ob [16];

   // key registers, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < aes_pkg::KEY_REGS; i++) key_ff[i] <= '0;
      end else if (csr_wen) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   // next four schedule words from the eight-word window
   always_comb begin
      t_word = win_ff[31:0];
      if (!cmd.exp_idx[0])
         t_word = aes_pkg::sub_word({t_word[23:0], t_word[31:24]}) ^ {rc_ff, 24'h0};
      else
         t_word = aes_pkg::sub_word(t_word);
      n0 = win_ff[255:224] ^ t_word;
      n1 = win_ff[223:192] ^ n0;
      n2 = win_ff[191:160] ^ n1;
      n3 = win_ff[159:128] ^ n2;
      win_in = {win_ff[127:0], n0, n1, n2, n3};
   end

   // key expansion window and round key store
   always_ff @(posedge clock) begin
      if (cmd.key_load) begin
         win_ff <= {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
         rc_ff  <= aes_pkg::RCON_INIT;
      end else if (cmd.exp_step) begin
         win_ff <= win_in;
         if (!cmd.exp_idx[0]) rc_ff <= aes_pkg::xtime(rc_ff);
         rk_mem[cmd.exp_idx] <= win_ff[255:128];
      end
   end

   // round key fetch, reversed order for decryption
   assign rd_dec  = cmd.rd_from_req ? req_tuser : dec_ff;
   assign rd_addr = rd_dec ? aes_pkg::RK_ADDR_W'(aes_pkg::ROUND_COUNT) - cmd.rd_round
                           : cmd.rd_round;

   always_ff @(posedge clock) begin
      rk_q_ff <= rk_mem[rd_addr];
   end

   // block byte 0 at the top
   assign blk_be = {req_tdata[63:0], req_tdata[127:64]};

   // one round: byte k of the state sits at bits 127-8k
   always_comb begin
      for (int k = 0; k < 16; k++) kb[k] = rk_q_ff[127-8*k -: 8];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (dec_ff)
               sb[r+4*c] = aes_pkg::INV_TAB[st_ff[127-8*(r+4*((c-r)&3)) -: 8]];
            else
               sb[r+4*c] = aes_pkg::FWD_TAB[st_ff[127-8*(r+4*((c+r)&3)) -: 8]];
         end
      end
      // decryption adds the key before the column mix
      for (int k = 0; k < 16; k++) mx[k] = dec_ff ? (sb[k] ^ kb[k]) : sb[k];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            ob[r+4*c] = 8'h00;
            for (int j = 0; j < 4; j++)
               ob[r+4*c] = ob[r+4*c] ^ aes_pkg::gf_mul(mx[((r+j)&3)+4*c],
                  dec_ff ? aes_pkg::MIX_INV[j] : aes_pkg::MIX_FWD[j]);
         end
      end
      for (int k = 0; k < 16; k++) begin
         if (cmd.last_round) ob[k] = mx[k];
         if (!dec_ff) ob[k] = ob[k] ^ kb[k];
         st_in[127-8*k -: 8] = ob[k];
      end
   end

   // cipher state
   always_ff @(posedge clock) begin
      if (cmd.blk_load) begin
         st_ff  <= blk_be;
         dec_ff <= req_tuser;
         fin_ff <= req_tlast;
      end else if (cmd.init) begin
         st_ff <= st_ff ^ rk_q_ff;
      end else if (cmd.round_en) begin
         st_ff <= st_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff     <= {st_ff[63:0], st_ff[127:64]};
         out_fin_ff <= fin_ff;
      end
   end

   assign rsp_tdata = out_ff;
   assign rsp_tlast = out_fin_ff;

endmodule

// ===== src/aes_checker.sv =====
`timescale 1ns / 1ps

module aes_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         csr_wen
);

   // key expansion runs after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("ready right after reset");

   // one word in flight
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken while busy");

   // key write blocks input during expansion
   a_key_busy: assert property (@(posedge clock) disable iff (reset)
      csr_wen |=> !req_tready)
      else $error("ready during key expansion");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind aes256_ecb_block_cipher aes_checker u_aes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_wen    (csr_wen)
);
